// ===== rtl/core/rsst_pkg.sv =====
package rsst_pkg;

  localparam int VALUE_W = 64;
  localparam int INDEX_W = 10;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUM  = 2'd2;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;

endpackage

// ===== rtl/core/rsst_ram.sv =====
module rsst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/range_add_range_sum_tree_core.sv =====
// Range add / range sum over ELEMENTS signed 64-bit elements, kept as two
// binary indexed trees in two 1-read 1-write RAMs (slope and offset terms).
// Sum: up to 2 prefix walks, each a read and accumulate per visited node and
// then a multiply and a finish step, followed by output. Add: 1 or 2 update
// walks, each a multiply then a read and write per node; load = sum walks + add.
// Reset (rst_n low, synchronous) starts a clearing pass over all ELEMENTS+1 words.
module range_add_range_sum_tree_core
  import rsst_pkg::*;
#(
  parameter int ELEMENTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cmd[1:0], index_lo[11:2], index_hi[21:12], value[85:22]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // range_sum[63:0]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int DEPTH = ELEMENTS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(DEPTH) + 1;
  localparam logic [KW-1:0] N_K = KW'(ELEMENTS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_QRD, S_QAC, S_QMUL, S_QFIN, S_UMUL, S_URD, S_UWR, S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [KW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [VALUE_W-1:0]   v_r, v_nxt;
  logic [KW-1:0]        k_r, k_nxt, korig_r, korig_nxt;
  logic [VALUE_W-1:0]   s1_r, s1_nxt, s2_r, s2_nxt;
  logic [VALUE_W-1:0]   prod_r, prod_nxt, pa_r, pa_nxt;
  logic                 phase_r, phase_nxt, upass_r, upass_nxt;
  logic [VALUE_W-1:0]   x_r, x_nxt, m_r, m_nxt, res_r, res_nxt;
  logic [KW-1:0]        ui_r, ui_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [VALUE_W-1:0]   wdata1, wdata2, rdata1, rdata2;

  logic [CMD_W-1:0]     in_cmd;
  logic [31:0]          in_a32, in_b32, b_clip;
  logic [VALUE_W-1:0]   in_value, pre, diff;
  logic                 a_ok, ok;
  logic [KW-1:0]        hi2;

  assign in_cmd   = in_tdata[1:0];
  assign in_a32   = 32'(in_tdata[11:2]);
  assign in_b32   = 32'(in_tdata[21:12]);
  assign in_value = in_tdata[85:22];
  assign b_clip   = (in_b32 >= 32'(ELEMENTS)) ? 32'(ELEMENTS - 1) : in_b32;
  assign a_ok     = in_a32 < 32'(ELEMENTS);
  assign ok       = a_ok && (in_a32 <= b_clip);
  assign pre      = prod_r - s2_r;
  assign diff     = pa_r - pre;
  assign hi2      = hi_r + KW'(2);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    v_nxt          = v_r;
    k_nxt          = k_r;
    korig_nxt      = korig_r;
    s1_nxt         = s1_r;
    s2_nxt         = s2_r;
    prod_nxt       = prod_r;
    pa_nxt         = pa_r;
    phase_nxt      = phase_r;
    upass_nxt      = upass_r;
    x_nxt          = x_r;
    m_nxt          = m_r;
    res_nxt        = res_r;
    ui_nxt         = ui_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    we             = 1'b0;
    waddr          = AW'(ui_r);
    wdata1         = '0;
    wdata2         = '0;
    raddr          = AW'(k_r);

    case (state_r)
      S_CLR: begin
        we     = 1'b1;
        waddr  = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(ELEMENTS)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          lo_nxt    = KW'(in_a32);
          v_nxt     = in_value;
          s1_nxt    = '0;
          s2_nxt    = '0;
          phase_nxt = 1'b0;
          upass_nxt = 1'b0;
          case (in_cmd)
            CMD_LOAD: begin
              hi_nxt    = KW'(in_a32);
              k_nxt     = KW'(in_a32) + KW'(1);
              korig_nxt = KW'(in_a32) + KW'(1);
              if (a_ok) begin
                state_nxt = S_QRD;
              end
            end
            CMD_ADD: begin
              hi_nxt = KW'(b_clip);
              x_nxt  = in_value;
              ui_nxt = KW'(in_a32) + KW'(1);
              if (ok) begin
                state_nxt = S_UMUL;
              end
            end
            CMD_SUM: begin
              hi_nxt    = KW'(b_clip);
              k_nxt     = KW'(b_clip) + KW'(1);
              korig_nxt = KW'(b_clip) + KW'(1);
              res_nxt   = '0;
              state_nxt = ok ? S_QRD : S_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      S_QRD: begin
        raddr     = AW'(k_r);
        state_nxt = S_QAC;
      end
      S_QAC: begin
        s1_nxt = s1_r + rdata1;
        s2_nxt = s2_r + rdata2;
        k_nxt  = k_r - (k_r & (~k_r + KW'(1)));
        state_nxt = (k_nxt == '0) ? S_QMUL : S_QRD;
      end
      S_QMUL: begin
        prod_nxt  = s1_r * VALUE_W'(korig_r);
        state_nxt = S_QFIN;
      end
      S_QFIN: begin
        if (!phase_r) begin
          // second walk: prefix over the elements below lo
          pa_nxt    = pre;
          phase_nxt = 1'b1;
          k_nxt     = lo_r;
          korig_nxt = lo_r;
          s1_nxt    = '0;
          s2_nxt    = '0;
          state_nxt = (lo_r == '0) ? S_QMUL : S_QRD;
        end else if (cmd_r == CMD_SUM) begin
          res_nxt   = diff;
          state_nxt = S_OUT;
        end else begin
          // load: add the difference to the old element value
          x_nxt     = v_r - diff;
          ui_nxt    = lo_r + KW'(1);
          state_nxt = S_UMUL;
        end
      end
      S_UMUL: begin
        m_nxt     = x_r * VALUE_W'(ui_r - KW'(1));
        state_nxt = S_URD;
      end
      S_URD: begin
        raddr     = AW'(ui_r);
        state_nxt = S_UWR;
      end
      S_UWR: begin
        we     = 1'b1;
        waddr  = AW'(ui_r);
        wdata1 = rdata1 + x_r;
        wdata2 = rdata2 + m_r;
        ui_nxt = ui_r + (ui_r & (~ui_r + KW'(1)));
        if (ui_nxt > N_K) begin
          if (!upass_r && (hi2 <= N_K)) begin
            upass_nxt = 1'b1;
            ui_nxt    = hi2;
            x_nxt     = '0 - x_r;
            state_nxt = S_UMUL;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_URD;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      phase_r      <= 1'b0;
      upass_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      phase_r      <= phase_nxt;
      upass_r      <= upass_nxt;
    end
    cmd_r       <= cmd_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    v_r         <= v_nxt;
    k_r         <= k_nxt;
    korig_r     <= korig_nxt;
    s1_r        <= s1_nxt;
    s2_r        <= s2_nxt;
    prod_r      <= prod_nxt;
    pa_r        <= pa_nxt;
    x_r         <= x_nxt;
    m_r         <= m_nxt;
    res_r       <= res_nxt;
    ui_r        <= ui_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  rsst_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_slope_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata1),
    .raddr (raddr),
    .rdata (rdata1)
  );

  rsst_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_offset_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata2),
    .raddr (raddr),
    .rdata (rdata2)
  );

  a_clr_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("request accepted during clearing pass");

  a_wr_addr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r != S_CLR) |-> (waddr != '0))
    else $error("tree write to unused slot zero");

  a_upd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UWR) |-> (ui_r != '0 && ui_r <= N_K))
    else $error("update walk left the tree");

  a_qry_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QRD) |-> (k_r != '0 && k_r <= N_K))
    else $error("prefix walk left the tree");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_tvalid_r || out_tready)) |=> out_tvalid_r)
    else $error("sum result not presented");

endmodule
